[src/ssgle_pkg.sv]
package ssgle_pkg;

  // field and coordinate widths
  localparam int COORD_BITS = 11;
  localparam int BOX_BITS   = 7;
  localparam int MAX_BOX    = 64;
  localparam int DIGIT_BITS = 4;
  localparam int POS_BITS   = 10;
  localparam int SEG_BITS   = 3;
  localparam int IN_BITS    = 24;
  localparam int OUT_BITS   = 48;
  localparam int CNT_BITS   = 4;
  localparam int PC_BITS    = 4;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [PC_BITS-1:0]    upc_t;
  typedef logic [SEG_BITS-1:0]   seg_t;

  // register indexes
  localparam logic REG_BOX_WIDTH  = 1'b0;
  localparam logic REG_BOX_HEIGHT = 1'b1;

  // segment numbers
  localparam seg_t SEG_NONE = 3'd0;
  localparam seg_t SEG_TOP  = 3'd1;
  localparam seg_t SEG_UL   = 3'd2;
  localparam seg_t SEG_UR   = 3'd3;
  localparam seg_t SEG_MID  = 3'd4;
  localparam seg_t SEG_LL   = 3'd5;
  localparam seg_t SEG_LR   = 3'd6;
  localparam seg_t SEG_BOT  = 3'd7;

  // micro-operations and branch conditions
  typedef enum logic [2:0] {
    OP_SETUP0,
    OP_SETUP1,
    OP_BAR,
    OP_VERT,
    OP_BAD,
    OP_DONE
  } uop_t;

  typedef enum logic [1:0] {
    CND_NONE,
    CND_ZERO,
    CND_REPEAT,
    CND_COL
  } ucond_t;

  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    seg_t   seg;
    upc_t   jmp;
    upc_t   nxt;
  } uword_t;

  // step addresses
  localparam upc_t PC_SETUP0 = 4'd0;
  localparam upc_t PC_SETUP1 = 4'd1;
  localparam upc_t PC_TOP    = 4'd2;
  localparam upc_t PC_BOT    = 4'd3;
  localparam upc_t PC_MID    = 4'd4;
  localparam upc_t PC_UL     = 4'd5;
  localparam upc_t PC_UR     = 4'd6;
  localparam upc_t PC_LL     = 4'd7;
  localparam upc_t PC_LR     = 4'd8;
  localparam upc_t PC_DONE   = 4'd9;
  localparam upc_t PC_BAD    = 4'd10;

  // control store
  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    case (pc)
      PC_SETUP0: w = '{OP_SETUP0, CND_NONE,   SEG_NONE, PC_DONE, PC_SETUP1};
      PC_SETUP1: w = '{OP_SETUP1, CND_ZERO,   SEG_NONE, PC_DONE, PC_TOP};
      PC_TOP:    w = '{OP_BAR,    CND_REPEAT, SEG_TOP,  PC_TOP,  PC_BOT};
      PC_BOT:    w = '{OP_BAR,    CND_REPEAT, SEG_BOT,  PC_BOT,  PC_MID};
      PC_MID:    w = '{OP_BAR,    CND_REPEAT, SEG_MID,  PC_MID,  PC_UL};
      PC_UL:     w = '{OP_VERT,   CND_NONE,   SEG_UL,   PC_UR,   PC_UR};
      PC_UR:     w = '{OP_VERT,   CND_NONE,   SEG_UR,   PC_LL,   PC_LL};
      PC_LL:     w = '{OP_VERT,   CND_NONE,   SEG_LL,   PC_LR,   PC_LR};
      PC_LR:     w = '{OP_VERT,   CND_COL,    SEG_LR,   PC_UL,   PC_DONE};
      PC_BAD:    w = '{OP_BAD,    CND_NONE,   SEG_NONE, PC_DONE, PC_DONE};
      default:   w = '{OP_DONE,   CND_NONE,   SEG_NONE, PC_DONE, PC_DONE};
    endcase
    return w;
  endfunction

  // lit segments per digit, bit k is segment k+1
  function automatic logic [6:0] glyph_mask(input logic [DIGIT_BITS-1:0] d);
    logic [6:0] m;
    case (d)
      4'd0:    m = 7'h77;
      4'd1:    m = 7'h24;
      4'd2:    m = 7'h5D;
      4'd3:    m = 7'h6D;
      4'd4:    m = 7'h2E;
      4'd5:    m = 7'h6B;
      4'd6:    m = 7'h7B;
      4'd7:    m = 7'h25;
      4'd8:    m = 7'h7F;
      4'd9:    m = 7'h6F;
      default: m = 7'h00;
    endcase
    return m;
  endfunction

  // corner gap (t + 1) / 3, at least 1, for thickness up to 9
  function automatic logic [1:0] gap_of(input logic [CNT_BITS-1:0] t);
    logic [1:0] g;
    case (t)
      4'd5, 4'd6, 4'd7: g = 2'd2;
      4'd8, 4'd9:       g = 2'd3;
      default:          g = 2'd1;
    endcase
    return g;
  endfunction

endpackage

[src/seven_segment_glyph_line_emitter.sv]
// channel   dir  handshake              payload
// in_       in   in_tvalid/in_tready    digit, pos_x, pos_y
// out_      out  out_tvalid/out_tready  span endpoints, segment; is_line, last
// cfg_      in   cfg_valid/cfg_ready    register index, write data
//
// a digit runs the setup steps, the bars and the vertical column steps, with thickness t
// up to 9; the step counter of the control store visits every row of a lit bar, one row
// of an unlit bar and every vertical column step, one step a cycle while not stalled.
// an invalid digit emits one beat and ends; a digit with zero thickness ends after setup.
// rst_n is synchronous; it restores box 26 x 41 and drops all beats in flight.
// a full output register with out_tready low freezes the sequencer on the emitting step.
module seven_segment_glyph_line_emitter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // digit [3:0], pos_x [13:4], pos_y [23:14]
  input  logic [ssgle_pkg::IN_BITS-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // x_start [10:0], y_start [21:11], x_end [32:22], y_end [43:33],
  // segment [46:44], zero [47]
  output logic [ssgle_pkg::OUT_BITS-1:0]      out_tdata,
  // is_line [0]
  output logic                                out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [ssgle_pkg::BOX_BITS-1:0]      cfg_data
);
  import ssgle_pkg::*;

  // configuration and item registers
  logic [BOX_BITS-1:0] width_r, height_r;
  logic                busy_r, busy_nxt;
  upc_t                pc_r, pc_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [6:0]          mask_r;
  logic [POS_BITS-1:0] px_r, py_r;

  // glyph geometry
  logic [CNT_BITS-1:0] t_r, t_nxt;
  logic [1:0]          g_r, g_nxt;
  logic [5:0]          m0_r, m0_nxt;
  logic [2:0]          jpeak_r, jpeak_nxt;

  // result register
  logic   out_valid_r;
  coord_t xs_r, ys_r, xe_r, ye_r;
  seg_t   seg_r;
  logic   line_r, last_r;

  uword_t              uw;
  logic [BOX_BITS-1:0] w_c, h_c;
  logic                in_fire, lit, emit_req, stall, emit_fire, take, more;
  coord_t              xs, ys, xe, ye;
  logic                is_line, last;

  assign uw        = ucode(pc_r);
  assign in_tready = !busy_r;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // box size clamped to the largest box
  assign w_c = (width_r > BOX_BITS'(MAX_BOX)) ? BOX_BITS'(MAX_BOX) : width_r;
  assign h_c = (height_r > BOX_BITS'(MAX_BOX)) ? BOX_BITS'(MAX_BOX) : height_r;

  // thickness: (6h+20)/41 by reciprocal 25/1024, w/3 by 43/128
  logic [8:0]          th_x;
  logic [13:0]         th_prod;
  logic [12:0]         w_prod;
  logic [5:0]          wd3;
  logic [CNT_BITS-1:0] t_raw, t_lo;
  logic [7:0]          m_tmp;
  always_comb begin
    th_x    = 9'(h_c) * 9'd6 + 9'd20;
    th_prod = 14'(th_x) * 14'd25;
    t_raw   = th_prod[13:10];
    w_prod  = 13'(w_c) * 13'd43;
    wd3     = w_prod[12:7];
    t_lo    = (t_raw < 4'd2) ? 4'd2 : t_raw;
    t_nxt   = (6'(t_lo) > wd3) ? wd3[3:0] : t_lo;
  end

  // gap, middle bar row and tip peak column from thickness
  always_comb begin
    g_nxt     = gap_of(t_r);
    m_tmp     = 8'(h_c) + 8'd1 - 8'(t_r);
    m0_nxt    = m_tmp[7] ? 6'd0 : m_tmp[6:1];
    jpeak_nxt = (t_r[3:1] == 3'd0) ? 3'd0 : t_r[3:1] - 3'd1;
  end

  // span endpoints for the current step
  coord_t     px_c, py_c, wm1, hm1, gi, inset, tip, ts, te, bs, be, lx, rx;
  logic [5:0] dd, dd_abs;
  logic [4:0] dj, dj_abs;
  logic       later;
  always_comb begin
    px_c   = coord_t'(px_r);
    py_c   = coord_t'(py_r);
    wm1    = coord_t'(w_c) - coord_t'(1);
    hm1    = coord_t'(h_c) - coord_t'(1);
    gi     = coord_t'(g_r) + coord_t'(cnt_r);
    // diamond inset of the middle bar
    dd     = {1'b0, cnt_r, 1'b0} + 6'd1 - 6'(t_r);
    dd_abs = dd[5] ? -dd : dd;
    inset  = coord_t'({g_r, 1'b0}) + coord_t'(dd_abs[5:1]);
    // pointed tips of the verticals
    dj     = 5'(cnt_r) - 5'(jpeak_r);
    dj_abs = dj[4] ? -dj : dj;
    tip    = coord_t'(jpeak_r) - coord_t'(dj_abs);
    ts     = gi;
    te     = coord_t'(m0_r) - coord_t'(1) + tip;
    bs     = coord_t'(m0_r) + coord_t'(t_r) - tip;
    be     = hm1 - gi;
    lx     = px_c + coord_t'(cnt_r);
    rx     = px_c + wm1 - coord_t'(cnt_r);

    lit     = 1'b0;
    later   = 1'b0;
    xs      = '0;
    ys      = '0;
    xe      = '0;
    ye      = '0;
    is_line = 1'b0;
    last    = 1'b0;
    case (uw.seg)
      SEG_TOP: begin
        lit = mask_r[0];
        xs  = px_c + gi;
        xe  = px_c + wm1 - gi;
        ys  = py_c + coord_t'(cnt_r);
        ye  = ys;
      end
      SEG_BOT: begin
        lit = mask_r[6];
        xs  = px_c + gi;
        xe  = px_c + wm1 - gi;
        ys  = py_c + hm1 - coord_t'(cnt_r);
        ye  = ys;
      end
      SEG_MID: begin
        lit = mask_r[3];
        xs  = px_c + inset;
        xe  = px_c + wm1 - inset;
        ys  = py_c + coord_t'(m0_r) + coord_t'(cnt_r);
        ye  = ys;
      end
      SEG_UL: begin
        lit   = mask_r[1];
        later = mask_r[2] | mask_r[4] | mask_r[5];
        xs    = lx;
        xe    = lx;
        ys    = py_c + ts;
        ye    = py_c + te;
      end
      SEG_UR: begin
        lit   = mask_r[2];
        later = mask_r[4] | mask_r[5];
        xs    = rx;
        xe    = rx;
        ys    = py_c + ts;
        ye    = py_c + te;
      end
      SEG_LL: begin
        lit   = mask_r[4];
        later = mask_r[5];
        xs    = lx;
        xe    = lx;
        ys    = py_c + bs;
        ye    = py_c + be;
      end
      SEG_LR: begin
        lit = mask_r[5];
        xs  = rx;
        xe  = rx;
        ys  = py_c + bs;
        ye  = py_c + be;
      end
      default: begin
        lit = 1'b0;
      end
    endcase

    // last column step with no lit vertical after this one ends the glyph
    more = (5'(cnt_r) + 5'd1) < 5'(t_r);
    if (uw.op == OP_BAD) begin
      last    = 1'b1;
      is_line = 1'b0;
    end else begin
      last    = (uw.op == OP_VERT) && !more && !later;
      is_line = 1'b1;
    end
  end

  // output handshake against the result register
  always_comb begin
    emit_req  = busy_r && ((((uw.op == OP_BAR) || (uw.op == OP_VERT)) && lit)
                           || (uw.op == OP_BAD));
    stall     = emit_req && out_valid_r && !out_tready;
    emit_fire = emit_req && !stall;
  end

  // sequencer next step
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    cnt_nxt  = cnt_r;
    take     = 1'b0;
    case (uw.cond)
      CND_ZERO:   take = (t_r == '0);
      CND_REPEAT: take = lit && more;
      CND_COL:    take = more;
      default:    take = 1'b0;
    endcase
    if (!busy_r) begin
      if (in_fire) begin
        busy_nxt = 1'b1;
        cnt_nxt  = '0;
        pc_nxt   = (in_tdata[DIGIT_BITS-1:0] > 4'd9) ? PC_BAD : PC_SETUP0;
      end
    end else if (!stall) begin
      if ((uw.op == OP_DONE) || (uw.op == OP_BAD)) begin
        busy_nxt = 1'b0;
      end else begin
        pc_nxt = take ? uw.jmp : uw.nxt;
        if (take && ((uw.cond == CND_REPEAT) || (uw.cond == CND_COL))) begin
          cnt_nxt = cnt_r + 4'd1;
        end else if (uw.cond == CND_REPEAT) begin
          cnt_nxt = '0;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= BOX_BITS'(26);
      height_r    <= BOX_BITS'(41);
      busy_r      <= 1'b0;
      pc_r        <= PC_DONE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BOX_WIDTH) begin
          width_r <= cfg_data;
        end else begin
          height_r <= cfg_data;
        end
      end
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      cnt_r  <= cnt_nxt;
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mask_r <= glyph_mask(in_tdata[DIGIT_BITS-1:0]);
      px_r   <= in_tdata[DIGIT_BITS +: POS_BITS];
      py_r   <= in_tdata[DIGIT_BITS+POS_BITS +: POS_BITS];
    end
    if (busy_r && (uw.op == OP_SETUP0)) begin
      t_r <= t_nxt;
    end
    if (busy_r && (uw.op == OP_SETUP1)) begin
      g_r     <= g_nxt;
      m0_r    <= m0_nxt;
      jpeak_r <= jpeak_nxt;
    end
    if (emit_fire) begin
      xs_r   <= is_line ? xs : '0;
      ys_r   <= is_line ? ys : '0;
      xe_r   <= is_line ? xe : '0;
      ye_r   <= is_line ? ye : '0;
      seg_r  <= is_line ? uw.seg : SEG_NONE;
      line_r <= is_line;
      last_r <= last;
    end
  end

  // result beat
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, seg_r, ye_r, xe_r, ys_r, xs_r};
  assign out_tuser  = line_r;
  assign out_tlast  = last_r;

endmodule

[bench/tb_seven_segment_glyph_line_emitter.sv]
module tb_seven_segment_glyph_line_emitter;
  import ssgle_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int LONG_HOLD     = 400;
  localparam int PRINT_CAP     = 100;

  // lit segments per digit, bit k is segment k+1
  localparam logic [6:0] DIGIT_SEGS [0:9] = '{
    7'h77, 7'h24, 7'h5D, 7'h6D, 7'h2E, 7'h6B, 7'h7B, 7'h25, 7'h7F, 7'h6F
  };

  typedef struct packed {
    coord_t     xs;
    coord_t     ys;
    coord_t     xe;
    coord_t     ye;
    seg_t       seg;
    logic       is_line;
    logic       last;
  } span_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_BITS-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;
  logic                out_tuser;
  logic                out_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = REG_BOX_WIDTH;
  logic [BOX_BITS-1:0] cfg_data = '0;

  // model copy of the box registers
  logic [BOX_BITS-1:0] box_w_reg;
  logic [BOX_BITS-1:0] box_h_reg;

  span_t expected_spans[$];
  span_t held_span;
  bit    have_held;
  span_t want_span;
  int    error_count = 0;
  int    burst_left = 0;

  // receiver stall state
  int hold_req_id = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_left = 0;

  seven_segment_glyph_line_emitter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string what, input int got, input int want);
    if (error_count < PRINT_CAP)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  function automatic int iabs(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // spans are held back by one so the final one of a digit can take last
  function automatic void add_span(input int x0, input int y0, input int x1, input int y1,
                                   input seg_t seg);
    if (have_held) expected_spans.push_back(held_span);
    held_span.xs      = coord_t'(x0);
    held_span.ys      = coord_t'(y0);
    held_span.xe      = coord_t'(x1);
    held_span.ye      = coord_t'(y1);
    held_span.seg     = seg;
    held_span.is_line = 1'b1;
    held_span.last    = 1'b0;
    have_held = 1'b1;
  endfunction

  // expected line spans of one glyph
  function automatic void predict_glyph(input logic [DIGIT_BITS-1:0] dig, input int px,
                                        input int py);
    int w, h, thick, gap, mid0, peak, inset, tip, ts, te, bs, be, lx, rx, i, j;
    logic [6:0] lit;
    span_t bad;
    if (dig > 4'd9) begin
      bad = '0;
      bad.last = 1'b1;
      expected_spans.push_back(bad);
      return;
    end
    lit = DIGIT_SEGS[dig];
    w = (box_w_reg > MAX_BOX) ? MAX_BOX : int'(box_w_reg);
    h = (box_h_reg > MAX_BOX) ? MAX_BOX : int'(box_h_reg);
    thick = (h * 6 + 20) / 41;
    if (thick < 2) thick = 2;
    if (thick > w / 3) thick = w / 3;
    gap = (thick + 1) / 3;
    if (gap < 1) gap = 1;
    mid0 = (h - thick + 1) / 2;
    peak = thick / 2 - 1;
    if (peak < 0) peak = 0;
    have_held = 1'b0;

    // horizontal bars
    if (lit[0])
      for (i = 0; i < thick; i++)
        add_span(px + gap + i, py + i, px + w - 1 - gap - i, py + i, SEG_TOP);
    if (lit[6])
      for (i = 0; i < thick; i++)
        add_span(px + gap + i, py + h - 1 - i, px + w - 1 - gap - i, py + h - 1 - i, SEG_BOT);
    if (lit[3])
      for (i = 0; i < thick; i++) begin
        inset = 2 * gap + iabs(2 * i - (thick - 1)) / 2;
        add_span(px + inset, py + mid0 + i, px + w - 1 - inset, py + mid0 + i, SEG_MID);
      end

    // verticals column by column with pointed tips
    for (j = 0; j < thick; j++) begin
      tip = peak - iabs(j - peak);
      ts = gap + j;
      te = mid0 - 1 + tip;
      bs = mid0 + thick - tip;
      be = h - 1 - gap - j;
      lx = px + j;
      rx = px + w - 1 - j;
      if (lit[1]) add_span(lx, py + ts, lx, py + te, SEG_UL);
      if (lit[2]) add_span(rx, py + ts, rx, py + te, SEG_UR);
      if (lit[4]) add_span(lx, py + bs, lx, py + be, SEG_LL);
      if (lit[5]) add_span(rx, py + bs, rx, py + be, SEG_LR);
    end

    if (have_held) begin
      held_span.last = 1'b1;
      expected_spans.push_back(held_span);
      have_held = 1'b0;
    end
  endfunction

  // one digit beat, with bursts and random gaps
  task automatic send_digit(input logic [DIGIT_BITS-1:0] dig, input logic [POS_BITS-1:0] px,
                            input logic [POS_BITS-1:0] py);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {py, px, dig};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    predict_glyph(dig, int'(px), int'(py));
  endtask

  // drain all expected spans, then let a digit with no span finish
  task automatic wait_idle();
    int waited;
    in_tvalid <= 1'b0;
    waited = 0;
    while (expected_spans.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_spans.size() != 0) begin
      flag_error("spans never delivered", 0, expected_spans.size());
      expected_spans.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_box(input logic idx, input logic [BOX_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_BOX_WIDTH) box_w_reg = val;
    else box_h_reg = val;
  endtask

  task automatic set_box(input logic [BOX_BITS-1:0] wv, input logic [BOX_BITS-1:0] hv);
    write_box(REG_BOX_WIDTH, wv);
    write_box(REG_BOX_HEIGHT, hv);
  endtask

  // every digit and both invalid extremes at the reset box
  task automatic test_reset_box();
    int d;
    for (d = 0; d < 10; d++)
      send_digit(d[3:0], 10'(d * 97), 10'(1023 - d * 61));
    send_digit(4'd10, 10'd0, 10'd0);
    send_digit(4'd15, 10'd1023, 10'd1023);
    send_digit(4'd8, 10'd1023, 10'd1023);
    wait_idle();
  endtask

  // oversized, minimum, zero-thickness and wrapping boxes
  task automatic test_box_extremes();
    set_box(7'd127, 7'd127);
    send_digit(4'd8, 10'd1023, 10'd1023);
    send_digit(4'd11, 10'd0, 10'd0);
    wait_idle();
    set_box(7'd6, 7'd8);
    send_digit(4'd8, 10'd5, 10'd7);
    wait_idle();
    // width too small for any stroke
    set_box(7'd0, 7'd41);
    send_digit(4'd8, 10'd100, 10'd100);
    send_digit(4'd3, 10'd0, 10'd0);
    send_digit(4'd13, 10'd512, 10'd512);
    wait_idle();
    // zero height drives rows negative and they wrap
    set_box(7'd26, 7'd0);
    send_digit(4'd8, 10'd0, 10'd0);
    wait_idle();
    set_box(7'd64, 7'd64);
    send_digit(4'd0, 10'd1023, 10'd0);
    wait_idle();
  endtask

  // long output stall while digits keep coming
  task automatic test_backpressure();
    int k;
    set_box(7'd64, 7'd64);
    hold_req_id <= hold_req_id + 1;
    for (k = 0; k < 8; k++)
      send_digit(4'd8, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    wait_idle();
  endtask

  // random boxes, each with a run of random digits
  task automatic test_random_glyphs();
    int phase, k;
    logic [BOX_BITS-1:0] wv, hv;
    logic [DIGIT_BITS-1:0] dig;
    logic [POS_BITS-1:0] px, py;
    for (phase = 0; phase < 10; phase++) begin
      if ($urandom_range(0, 4) == 0) begin
        wv = 7'($urandom_range(0, 127));
        hv = 7'($urandom_range(0, 127));
      end else begin
        wv = 7'($urandom_range(6, 64));
        hv = 7'($urandom_range(8, 64));
      end
      set_box(wv, hv);
      for (k = 0; k < 30; k++) begin
        dig = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
        px = 10'($urandom_range(0, 1023));
        py = 10'($urandom_range(0, 1023));
        if ($urandom_range(0, 7) == 0) px = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        if ($urandom_range(0, 7) == 0) py = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        send_digit(dig, px, py);
      end
      wait_idle();
    end
  endtask

  // receiver: long hold on request, otherwise its own stall pattern
  always @(posedge clk) begin
    if (hold_req_id != hold_seen) begin
      hold_seen  <= hold_req_id;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_left <= $urandom_range(10, 150);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // span checker against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_spans.size() == 0) begin
        flag_error("span beat with nothing expected", int'(out_tdata[31:0]), 0);
      end else begin
        want_span = expected_spans.pop_front();
        if (out_tdata[10:0] !== want_span.xs)
          flag_error("x_start", int'(out_tdata[10:0]), int'(want_span.xs));
        if (out_tdata[21:11] !== want_span.ys)
          flag_error("y_start", int'(out_tdata[21:11]), int'(want_span.ys));
        if (out_tdata[32:22] !== want_span.xe)
          flag_error("x_end", int'(out_tdata[32:22]), int'(want_span.xe));
        if (out_tdata[43:33] !== want_span.ye)
          flag_error("y_end", int'(out_tdata[43:33]), int'(want_span.ye));
        if (out_tdata[46:44] !== want_span.seg)
          flag_error("segment", int'(out_tdata[46:44]), int'(want_span.seg));
        if (out_tdata[47] !== 1'b0)
          flag_error("pad bit", int'(out_tdata[47]), 0);
        if (out_tuser !== want_span.is_line)
          flag_error("is_line", int'(out_tuser), int'(want_span.is_line));
        if (out_tlast !== want_span.last)
          flag_error("last", int'(out_tlast), int'(want_span.last));
      end
    end
  end

  initial begin
    box_w_reg = 7'd26;
    box_h_reg = 7'd41;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_box();
    test_box_extremes();
    test_backpressure();
    test_random_glyphs();
    wait_idle();
    if (error_count == 0) begin
      $display("tb_seven_segment_glyph_line_emitter passed");
    end else begin
      $display("tb_seven_segment_glyph_line_emitter failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb_seven_segment_glyph_line_emitter failed");
    $finish;
  end

endmodule
